// ----- sv/msp_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// msp_pkg
// shared types, widths and the saturating sum helper for the
// max-sum ordered pair subsequence block
// ---------------------------------------------------------------------------
package msp_pkg;

    localparam int KEY_W       = 16;
    localparam int WEIGHT_W    = 20;
    localparam int SUM_W       = 28;
    localparam int DEF_MAX_ITEMS = 256;

    localparam int IN_DATA_W   = 40;   // age + score, padded to bytes
    localparam int OUT_DATA_W  = 32;   // best_total, padded to bytes

    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [SUM_W-1:0]    t_sum;

    // one stored entry of the sorted row
    typedef struct packed {
        logic    valid;
        t_key    key;
        t_weight weight;
        t_sum    prior;   // best chain sum among earlier entries it may follow
    } t_entry;

    // what a cell hands to its right neighbor
    typedef struct packed {
        t_entry ent;
        logic   after;    // entry orders strictly after the incoming word
    } t_link;

    // broadcast controls from the sequencer
    typedef struct packed {
        logic    ins;
        logic    pop;
        t_key    key;
        t_weight weight;
        t_weight head_weight;
        t_sum    head_best;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_SOLVE = 2'b10
    } t_state;

    // prior + weight, clamped at the top of the sum range
    function automatic t_sum sat_add(input t_sum prior, input t_weight weight);
        logic [SUM_W:0] full_sum;
        full_sum = {1'b0, prior} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, weight};
        if (full_sum[SUM_W]) begin
            return {SUM_W{1'b1}};
        end
        return full_sum[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/max_sum_ordered_pair_subsequence.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// max_sum_ordered_pair_subsequence
// largest score sum over non-decreasing chains of (age, score) words
// ---------------------------------------------------------------------------
// Words of a set stream in one per cycle while loading and drop into a row
// of MAX_ITEMS cells that keeps them sorted by age, then score, as they
// arrive. The word flagged by tuser ends the set: the row then shifts
// toward cell 0 one entry per cycle, the head entry's chain sum is formed
// by the single head adder and broadcast to every later entry, and the
// best sum is posted when the row is empty and the output slot is free.
// Words beyond MAX_ITEMS are dropped, though their last flag still closes
// the set. Input is not taken while solving; the result sits in an output
// register, so the next set can load while it waits to be taken.
// ---------------------------------------------------------------------------
module max_sum_ordered_pair_subsequence #(
    parameter int MAX_ITEMS = msp_pkg::DEF_MAX_ITEMS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [msp_pkg::IN_DATA_W-1:0]   i_s_tdata,   // age, score, zero pad
    input  wire logic                            i_s_tuser,   // last
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [msp_pkg::OUT_DATA_W-1:0]       o_m_tdata    // best_total, zero pad
);
    import msp_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    t_sum             r_run;      // running max of chain sums in this pass
    logic             r_out_valid;
    t_sum             r_out_data;

    t_link            w_link [MAX_ITEMS];
    t_cell_ctl        w_ctl;
    t_key             w_key;
    t_weight          w_weight;
    logic             w_accept;
    logic             w_full;
    logic             w_pop;
    logic             w_emit;
    t_sum             w_head_best;

    assign w_key    = i_s_tdata[KEY_W-1:0];
    assign w_weight = i_s_tdata[KEY_W+WEIGHT_W-1:KEY_W];

    assign o_s_tready = (r_state == ST_LOAD);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CNT_W'(MAX_ITEMS));
    assign w_pop      = (r_state == ST_SOLVE) && (r_count != '0);
    assign w_emit     = (r_state == ST_SOLVE) && (r_count == '0) &&
                        (!r_out_valid || i_m_tready);

    // chain sum of the entry leaving the head of the row
    assign w_head_best = sat_add(w_link[0].ent.prior, w_link[0].ent.weight);

    always_comb begin
        w_ctl.ins         = w_accept && !w_full;
        w_ctl.pop         = w_pop;
        w_ctl.key         = w_key;
        w_ctl.weight      = w_weight;
        w_ctl.head_weight = w_link[0].ent.weight;
        w_ctl.head_best   = w_head_best;
    end

    // row of sorting cells
    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        t_link  w_left;
        t_entry w_right;

        if (g == 0) begin : g_first
            // the slot left of cell 0 acts as a filled entry that never moves
            always_comb begin
                w_left           = '0;
                w_left.ent.valid = 1'b1;
            end
        end else begin : g_inner
            assign w_left = w_link[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_link[g+1].ent;
        end

        msp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_left  (w_left),
            .i_right (w_right),
            .i_ctl   (w_ctl),
            .o_link  (w_link[g])
        );
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result may replace the one taken in the same cycle
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (!w_full) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_s_tuser) begin
                            r_run   <= '0;
                            r_state <= ST_SOLVE;
                        end
                    end
                end
                ST_SOLVE: begin
                    if (w_pop) begin
                        r_count <= r_count - 1'b1;
                        if (w_head_best > r_run) begin
                            r_run <= w_head_best;
                        end
                    end else if (w_emit) begin
                        r_state <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= r_run;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - SUM_W){1'b0}}, r_out_data};

    // fill count never passes the row length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("fill count beyond row length");

    // head cell holds an entry exactly when the row is not empty
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) == w_link[0].ent.valid)
        else $error("head valid disagrees with fill count");

    // a result is posted only at the end of a solve pass
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_SOLVE) && (r_state == ST_LOAD))
        else $error("result posted outside solve");

    // a word is never taken while solving
    a_no_load_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SOLVE) |-> !w_accept)
        else $error("word accepted during solve");

endmodule
`default_nettype wire

// ----- sv/msp_cell.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// msp_cell
// one slot of the sorted row: insertion shift on load, left shift with
// prior update on solve
// ---------------------------------------------------------------------------
module msp_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire msp_pkg::t_link     i_left,
    input  wire msp_pkg::t_entry    i_right,
    input  wire msp_pkg::t_cell_ctl i_ctl,
    output msp_pkg::t_link          o_link
);
    import msp_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic   w_after;

    assign w_after = r_ent.valid &&
                     ((r_ent.key > i_ctl.key) ||
                      ((r_ent.key == i_ctl.key) && (r_ent.weight > i_ctl.weight)));

    always_comb begin
        n_ent = r_ent;
        priority if (i_ctl.ins) begin
            if (i_left.after) begin
                n_ent = i_left.ent;
            end else if (w_after || (!r_ent.valid && i_left.ent.valid)) begin
                n_ent.valid  = 1'b1;
                n_ent.key    = i_ctl.key;
                n_ent.weight = i_ctl.weight;
                n_ent.prior  = '0;
            end
        end else if (i_ctl.pop) begin
            n_ent = i_right;
            if (i_right.valid && (i_ctl.head_weight <= i_right.weight) &&
                (i_ctl.head_best > i_right.prior)) begin
                n_ent.prior = i_ctl.head_best;
            end
        end else begin
            // idle, entry holds
            n_ent = r_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid  <= 1'b0;
            r_ent.key    <= n_ent.key;
            r_ent.weight <= n_ent.weight;
            r_ent.prior  <= n_ent.prior;
        end else begin
            r_ent <= n_ent;
        end
    end

    assign o_link.ent   = r_ent;
    assign o_link.after = w_after;

endmodule
`default_nettype wire

// ----- test/tb_max_sum_ordered_pair_subsequence.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_max_sum_ordered_pair_subsequence
// self-checking bench for the max-sum ordered pair subsequence block
// ---------------------------------------------------------------------------
// Streams sets of (age, score) words into the block with random gaps on
// both handshakes. A scoreboard keeps its own sorted copy of each set and
// works out the best non-decreasing chain total when the closing word is
// taken, then checks every result word against the oldest total due.
// Directed sets cover the field extremes, ties and duplicates; the random
// part mixes wide and narrow value ranges, and two sets fill the row to
// capacity and beyond it.
// ---------------------------------------------------------------------------

import msp_pkg::*;

class msp_scoreboard;
    int unsigned cap;
    t_key        row_keys[$];
    t_weight     row_weights[$];
    t_sum        totals_due[$];
    int          errors;

    function new(int unsigned set_cap);
        cap    = set_cap;
        errors = 0;
    endfunction

    function int pending();
        return totals_due.size();
    endfunction

    // sorted insert after equal entries, full row drops the word
    function void note_word(t_key age, t_weight score, logic last);
        int              pos;
        int              i;
        int              j;
        t_sum            prior;
        t_sum            best;
        t_sum            top;
        t_sum            ending[];
        longint unsigned sum;
        pos = row_keys.size();
        if (pos < cap) begin
            while (pos > 0 && (row_keys[pos-1] > age ||
                   (row_keys[pos-1] == age && row_weights[pos-1] > score))) begin
                pos--;
            end
            row_keys.insert(pos, age);
            row_weights.insert(pos, score);
        end
        if (last) begin
            top    = '1;
            best   = '0;
            ending = new[row_keys.size()];
            for (i = 0; i < row_keys.size(); i++) begin
                prior = '0;
                for (j = 0; j < i; j++) begin
                    if (row_weights[j] <= row_weights[i] && ending[j] > prior) begin
                        prior = ending[j];
                    end
                end
                sum = 64'(prior) + 64'(row_weights[i]);
                ending[i] = (sum > 64'(top)) ? top : t_sum'(sum);
                if (ending[i] > best) begin
                    best = ending[i];
                end
            end
            totals_due.insert(totals_due.size(), best);
            row_keys.delete();
            row_weights.delete();
        end
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task check_total(logic [OUT_DATA_W-1:0] data);
        t_sum want;
        if (totals_due.size() == 0) begin
            report($sformatf("result word %h with no total due", data));
            return;
        end
        want = totals_due.pop_front();
        if (data[SUM_W-1:0] !== want) begin
            report($sformatf("best_total %0d, want %0d", data[SUM_W-1:0], want));
        end
        if (data[OUT_DATA_W-1:SUM_W] !== '0) begin
            report($sformatf("pad bits of result word %h not zero", data));
        end
    endtask
endclass

module tb_max_sum_ordered_pair_subsequence;

    localparam int SET_CAP      = DEF_MAX_ITEMS;
    localparam int RANDOM_WORDS = 780;
    localparam int CYCLE_LIMIT  = 400000;
    // solve pass of a full row plus margin
    localparam int DRAIN_CYCLES = 4 * SET_CAP + 100;
    localparam int PAD_W        = IN_DATA_W - KEY_W - WEIGHT_W;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;   // age, score, zero pad
    logic                  i_s_tuser  = 1'b0; // last
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;         // best_total, zero pad

    msp_scoreboard board = new(SET_CAP);

    // no-idle stretch on both sides while set
    bit steady = 1'b0;
    int cycles = 0;

    max_sum_ordered_pair_subsequence #(
        .MAX_ITEMS (SET_CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one input word: random gap, then hold valid until the edge that takes it.
    // valid stays high on return so a back-to-back word needs no second write
    task automatic send_word(input t_key age, input t_weight score, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{PAD_W{1'b0}}, score, age};
        i_s_tuser  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_word(age, score, last);
    endtask

    // result side: random stall before each word, then take it
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 11);
            repeat (gap) begin
                i_m_tready <= 1'b0;
                @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            board.check_total(o_m_tdata);
        end
    end

    initial begin
        int      sent;
        int      set_no;
        int      size;
        int      i;
        int      age_style;
        int      score_style;
        t_key    age;
        t_weight score;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed sets ----
        // single word at the bottom of both fields
        send_word(16'h0000, 20'h00000, 1'b1);
        // single word at the top of both fields
        send_word(16'hFFFF, 20'hFFFFF, 1'b1);
        // max age with zero score, min age with max score: chain cannot hold both
        send_word(16'hFFFF, 20'h00000, 1'b0);
        send_word(16'h0000, 20'hFFFFF, 1'b1);
        // duplicates of one word all chain together
        send_word(16'd5, 20'd7, 1'b0);
        send_word(16'd5, 20'd7, 1'b0);
        send_word(16'd5, 20'd7, 1'b1);
        // same age, scores out of order: tie broken by score
        send_word(16'd3, 20'd9, 1'b0);
        send_word(16'd3, 20'd2, 1'b0);
        send_word(16'd3, 20'd5, 1'b1);
        // scores fall as age rises: only one word counts
        send_word(16'd1, 20'd10, 1'b0);
        send_word(16'd2, 20'd5, 1'b0);
        send_word(16'd3, 20'd1, 1'b1);
        // arrives largely in reverse age order, equal scores allowed along the chain
        send_word(16'd9, 20'd4, 1'b0);
        send_word(16'd7, 20'd4, 1'b0);
        send_word(16'd4, 20'd1, 1'b0);
        send_word(16'd0, 20'd8, 1'b0);
        send_word(16'd7, 20'd2, 1'b1);
        // all scores zero
        send_word(16'd100, 20'd0, 1'b0);
        send_word(16'd50, 20'd0, 1'b1);
        i_s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);

        // ---- random sets ----
        sent   = 0;
        set_no = 0;
        while (sent < RANDOM_WORDS) begin
            set_no++;
            if (set_no == 3) begin
                // row filled exactly
                size = SET_CAP;
            end else if (set_no == 17) begin
                // words past capacity get dropped, last still closes the set
                size = SET_CAP + $urandom_range(1, 6);
            end else if ($urandom_range(0, 9) == 0) begin
                size = $urandom_range(13, 40);
            end else begin
                size = $urandom_range(1, 12);
            end
            age_style   = $urandom_range(0, 3);
            score_style = $urandom_range(0, 3);
            steady      = ($urandom_range(0, 3) == 0);
            for (i = 0; i < size; i++) begin
                case (age_style)
                    0: age = t_key'($urandom);
                    1: age = t_key'($urandom_range(0, 7));       // many ties
                    2: age = $urandom_range(0, 1) ? '1 : '0;
                    default: age = $urandom_range(0, 1) ? t_key'(i) : t_key'(16'hFFFF - i);
                endcase
                case (score_style)
                    0: score = t_weight'($urandom);
                    1: score = t_weight'($urandom_range(0, 15));
                    2: score = $urandom_range(0, 1) ? '1 : t_weight'($urandom_range(0, 1));
                    default: score = t_weight'($urandom_range(0, 1023));
                endcase
                send_word(age, score, i == size - 1);
            end
            sent += size;
            // now and then hold the sender until every total has come back
            if (set_no % 8 == 0) begin
                i_s_tvalid <= 1'b0;
                while (board.pending() != 0) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;
        steady     = 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/msp_pkg.sv
sv/msp_cell.sv
sv/max_sum_ordered_pair_subsequence.sv
test/tb_max_sum_ordered_pair_subsequence.sv
